// ===== rtl/header_walk_block_allocator_top_defines.svh =====
// Assertion macros used by the checker file of the allocator.
`ifndef HEADER_WALK_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define HEADER_WALK_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Implication checked in the same cycle, switched off while reset is high.
`define HWBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle, switched off while reset is high.
`define HWBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Implication checked in the next cycle, also across reset.
`define HWBA_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/hwba_pkg.sv =====
`default_nettype none

package hwba_pkg;

  // Region geometry.
  localparam int REGION_WORDS = 4096;
  localparam int ADDR_W       = $clog2(REGION_WORDS);

  // Field widths of the request and the response.
  localparam int SIZE_W = 13;
  localparam int OFF_W  = 12;

  // Width of the walk pointer: it must hold an offset plus one stored size.
  localparam int WALK_W = ((ADDR_W > SIZE_W) ? ADDR_W : SIZE_W) + 1;

  // Header word: valid, in use, size.
  typedef struct packed {
    logic              valid;
    logic              used;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  // Request kinds.
  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } state_t;

  // Header store access from the controller.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    hdr_t              wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  // One response.
  typedef struct packed {
    logic             fail;
    logic [OFF_W-1:0] offset;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/hwba_mem.sv =====
`default_nettype none

module hwba_mem
  import hwba_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_req_t mem_req,
  output hdr_t          rd_data
);

  hdr_t store [REGION_WORDS];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      store[mem_req.wr_addr] <= mem_req.wr_data;
    end
    if (mem_req.rd_en) begin
      rd_data <= store[mem_req.rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hwba_ctrl.sv =====
`default_nettype none

module hwba_ctrl
  import hwba_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_cmd,
  input  wire logic [SIZE_W-1:0] in_req_size,
  input  wire logic [OFF_W-1:0]  in_block_offset,
  output mem_req_t               mem_req,
  input  wire hdr_t              mem_rd_data,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output res_t                   res
);

  state_t              state;
  state_t              state_next;
  logic [ADDR_W-1:0]   clr_cnt;
  logic [WALK_W-1:0]   pos;
  cmd_t                cmd_r;
  logic [SIZE_W-1:0]   req_r;
  logic [OFF_W-1:0]    off_r;
  logic                res_fail;
  logic [OFF_W-1:0]    res_off;

  logic                accept;
  logic                early_fail;
  logic                clr_last;
  logic [ADDR_W-1:0]   cur_addr;
  logic [WALK_W-1:0]   next_pos;
  logic [WALK_W:0]     new_end;
  logic                ev_done;
  logic                ev_fail;
  logic                ev_write;
  hdr_t                ev_hdr;
  logic                walk_on;

  assign accept   = in_valid && in_ready;
  assign clr_last = (clr_cnt == ADDR_W'(REGION_WORDS - 1));
  assign cur_addr = (cmd_r == CMD_FREE) ? ADDR_W'(off_r) : pos[ADDR_W-1:0];
  assign next_pos = pos + WALK_W'(mem_rd_data.size);
  assign new_end  = (WALK_W + 1)'(pos) + (WALK_W + 1)'(req_r);

  // A zero-size allocate or a free outside the region fails without touching the store.
  always_comb begin
    if (cmd_t'(in_cmd) == CMD_ALLOC) begin
      early_fail = (in_req_size == '0);
    end else begin
      early_fail = ((WALK_W + 1)'(in_block_offset) >= (WALK_W + 1)'(REGION_WORDS));
    end
  end

  // Decision on the header just read.
  always_comb begin
    ev_done  = 1'b0;
    ev_fail  = 1'b0;
    ev_write = 1'b0;
    walk_on  = 1'b0;
    ev_hdr   = '{valid: 1'b1, used: 1'b1, size: req_r};
    if (cmd_r == CMD_FREE) begin
      ev_done  = 1'b1;
      ev_fail  = !mem_rd_data.valid;
      ev_write = mem_rd_data.valid;
      ev_hdr   = '{valid: 1'b1, used: 1'b0, size: mem_rd_data.size};
    end else if (!mem_rd_data.valid) begin
      // End of the list: place a new block if it fits in the region.
      ev_done  = 1'b1;
      ev_fail  = (new_end > (WALK_W + 1)'(REGION_WORDS));
      ev_write = !ev_fail;
    end else if ((mem_rd_data.size != '0) && (mem_rd_data.size >= req_r)
                 && !mem_rd_data.used) begin
      // First fit: reuse this free block.
      ev_done  = 1'b1;
      ev_write = 1'b1;
    end else if ((mem_rd_data.size == '0)
                 || (next_pos >= WALK_W'(REGION_WORDS))) begin
      ev_done = 1'b1;
      ev_fail = 1'b1;
    end else begin
      walk_on = 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = early_fail ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (ev_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Outputs and store accesses.
  always_comb begin
    in_ready        = 1'b0;
    res_valid       = 1'b0;
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = cur_addr;
    mem_req.wr_data = ev_hdr;
    mem_req.rd_en   = 1'b0;
    mem_req.rd_addr = cur_addr;
    case (state)
      ST_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = clr_cnt;
        mem_req.wr_data = '0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_READ: begin
        mem_req.rd_en = 1'b1;
      end
      ST_EVAL: begin
        mem_req.wr_en   = ev_write;
        // While walking, the next header is fetched straight away.
        mem_req.rd_en   = walk_on;
        mem_req.rd_addr = next_pos[ADDR_W-1:0];
      end
      ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign res.fail   = res_fail;
  assign res.offset = res_off;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Request and walk registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= cmd_t'(in_cmd);
      req_r    <= in_req_size;
      off_r    <= in_block_offset;
      pos      <= '0;
      res_fail <= 1'b1;
      res_off  <= '0;
    end else if (state == ST_EVAL) begin
      if (walk_on) begin
        pos <= next_pos;
      end
      if (ev_done) begin
        res_fail <= ev_fail;
        res_off  <= (ev_fail || (cmd_r == CMD_FREE)) ? '0 : pos[OFF_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/header_walk_block_allocator_top.sv =====
// First-fit block allocator over a region of 4096 words with an implicit header list.
// Input channel s_*: s_tuser carries the request kind (0 allocate, 1 free), s_tdata
// carries the requested size and the block offset. Output channel m_*: m_tuser is the
// status (0 success, 1 failure), m_tdata the granted offset.
// One response leaves for every request, in request order.
// An allocate walks the headers from offset 0, one header per cycle through the single
// read port of the header memory. It passes the states READ, EVAL (repeated for each
// header visited) and DONE; its response then enters the output register as the
// controller returns to IDLE, where s_tready rises again. A free passes READ, EVAL and
// DONE once each. A zero-size allocate or a free beyond the region goes from IDLE
// straight to DONE and then into the output register.
// The controller handles one request at a time; the next request is taken once the
// previous response has gone into the output register.
// After reset the header memory is cleared one entry per cycle, all 4096 entries, and
// s_tready stays low during that pass.
// When the receiver stalls, the response is held in the output register; one further
// request may be taken and worked on, and its response waits in the controller.
`default_nettype none

module header_walk_block_allocator_top
  import hwba_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // req_size [12:0], block_offset [24:13], zeros above
  input  wire logic        s_tuser,  // cmd [0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,  // granted_offset [11:0], zeros above
  output logic             m_tuser   // status [0]
);

  mem_req_t mem_req;
  hdr_t     mem_rd_data;
  logic     res_valid;
  logic     res_ready;
  res_t     res;
  logic     out_valid;
  res_t     out_res;

  hwba_mem u_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (mem_rd_data)
  );

  hwba_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .in_cmd          (s_tuser),
    .in_req_size     (s_tdata[SIZE_W-1:0]),
    .in_block_offset (s_tdata[SIZE_W+OFF_W-1:SIZE_W]),
    .mem_req         (mem_req),
    .mem_rd_data     (mem_rd_data),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res)
  );

  // Output register: takes a response whenever it is empty or being drained.
  assign res_ready = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.fail;
  assign m_tdata  = 16'(out_res.offset);

endmodule

`default_nettype wire

// ===== rtl/hwba_chk.sv =====
`default_nettype none
`include "header_walk_block_allocator_top_defines.svh"

module hwba_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic        m_tuser
);

  // A stalled response keeps its contents.
  `HWBA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "response changed while stalled")

  // The header memory is being cleared right after reset, so no request is taken.
  `HWBA_ASSERT_RST(a_clear_busy, rst, !s_tready && !m_tvalid, "request port open during clear pass")

  // Requests are handled one at a time: the port closes after each one.
  `HWBA_ASSERT_NEXT(a_one_at_time, s_tvalid && s_tready, !s_tready, "request taken while busy")

  // A failed request never grants an offset.
  `HWBA_ASSERT_NOW(a_fail_zero, m_tvalid && m_tuser, m_tdata == 16'h0000, "failure with nonzero offset")

endmodule

bind header_walk_block_allocator_top hwba_chk u_hwba_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hwba_pkg::*;

  // One request as the driver sends it.
  typedef struct {
    cmd_t              cmd;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  off;
  } alloc_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;  // req_size [12:0], block_offset [24:13], zeros above
  logic        s_tuser = 1'b0;  // cmd [0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;  // granted_offset [11:0], zeros above
  logic        m_tuser;  // status [0]

  // Testbench state: pending requests, predicted responses and the shadow header store.
  alloc_req_t       pending_requests[$];
  res_t             expected_responses[$];
  logic [OFF_W-1:0] live_blocks[$];
  hdr_t             shadow_headers[REGION_WORDS];

  alloc_req_t next_req;
  res_t       predicted;
  int         walked;
  int         send_gap = 0;
  int         recv_stall = 0;
  bit         send_burst = 1'b0;
  bit         recv_burst = 1'b0;
  int         error_count = 0;
  longint     cycle_count = 0;
  longint     cycle_limit = 4 * REGION_WORDS + 2000;

  header_walk_block_allocator_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  // Predict the response to one request and update the shadow store. The number of
  // headers visited by an allocate is returned so that the time budget can follow it.
  function automatic res_t predict_response(input cmd_t cmd, input logic [SIZE_W-1:0] size,
                                            input logic [OFF_W-1:0] off, output int visits);
    res_t r;
    hdr_t h;
    int   pos;
    bit   done;
    r = '{fail: 1'b1, offset: '0};
    visits = 0;
    if (cmd == CMD_FREE) begin
      // A 12-bit offset always lies inside the region, so only the valid bit matters.
      if (shadow_headers[off].valid) begin
        shadow_headers[off].used = 1'b0;
        r.fail = 1'b0;
      end
    end else if (size != 0) begin
      pos = 0;
      done = 1'b0;
      while (!done && pos < REGION_WORDS) begin
        h = shadow_headers[pos];
        visits++;
        if (!h.valid) begin
          // First empty slot: append a new block if it still fits in the region.
          if (pos + int'(size) <= REGION_WORDS) begin
            shadow_headers[pos] = '{valid: 1'b1, used: 1'b1, size: size};
            r = '{fail: 1'b0, offset: pos[OFF_W-1:0]};
          end
          done = 1'b1;
        end else if (h.size != 0 && h.size >= size && !h.used) begin
          // First fit among the freed blocks; the stored size shrinks to the request.
          shadow_headers[pos] = '{valid: 1'b1, used: 1'b1, size: size};
          r = '{fail: 1'b0, offset: pos[OFF_W-1:0]};
          done = 1'b1;
        end else if (h.size == 0) begin
          done = 1'b1;
        end else begin
          pos += h.size;
        end
      end
    end
    return r;
  endfunction

  task automatic queue_request(input cmd_t cmd, input int size, input int off);
    alloc_req_t r;
    r.cmd = cmd;
    r.size = size[SIZE_W-1:0];
    r.off = off[OFF_W-1:0];
    pending_requests.push_back(r);
  endtask

  // Compare one response with the oldest prediction.
  task automatic check_response(input logic status, input logic [OFF_W-1:0] offset);
    res_t want;
    if (expected_responses.size() == 0) begin
      $error("unexpected response: status %0d granted_offset %0d", status, offset);
      error_count++;
    end else begin
      want = expected_responses.pop_front();
      if (status !== want.fail) begin
        $error("status: expected %0d, actual %0d", want.fail, status);
        error_count++;
      end
      if (offset !== want.offset) begin
        $error("granted_offset: expected %0d, actual %0d", want.offset, offset);
        error_count++;
      end
    end
  endtask

  // Driver: predicts each accepted request and presents the next one after a random gap.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predicted = predict_response(cmd_t'(s_tuser), s_tdata[SIZE_W-1:0],
                                     s_tdata[SIZE_W+OFF_W-1:SIZE_W], walked);
        expected_responses.push_back(predicted);
        if (s_tuser == CMD_ALLOC && !predicted.fail) live_blocks.push_back(predicted.offset);
        cycle_limit <= cycle_limit + 4 * (walked + 40);
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap != 0) begin
          send_gap = send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          next_req = pending_requests.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= next_req.cmd;
          s_tdata <= {7'b0, next_req.off, next_req.size};
          if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 9);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted response, then stalls the output for a random time.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_stall = 0;
    end else if (m_tvalid && m_tready) begin
      check_response(m_tuser, m_tdata[OFF_W-1:0]);
      if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
      recv_stall = recv_burst ? 0 : $urandom_range(0, 9);
      m_tready <= (recv_stall == 0);
    end else if (recv_stall != 0) begin
      recv_stall = recv_stall - 1;
      m_tready <= (recv_stall == 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Time budget: grows with the work of every accepted request.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_limit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    int pick;
    int idx;
    int size;
    foreach (shadow_headers[i]) shadow_headers[i] = '0;

    // Directed part: size extremes, region end, reuse with shrinking and the free cases.
    queue_request(CMD_ALLOC, 0, 0);        // zero size fails
    queue_request(CMD_ALLOC, 8191, 4095);  // oversized, every bit set
    queue_request(CMD_ALLOC, 4097, 0);     // just above the region
    queue_request(CMD_ALLOC, 4096, 0);     // whole region at offset 0
    queue_request(CMD_ALLOC, 1, 0);        // walk runs off the region end
    queue_request(CMD_FREE, 0, 4095);      // no header there
    queue_request(CMD_FREE, 8191, 0);
    queue_request(CMD_FREE, 0, 0);         // already free, still succeeds
    queue_request(CMD_ALLOC, 1, 0);        // reuse, block shrinks to one word
    queue_request(CMD_ALLOC, 4096, 0);     // new block would pass the end
    queue_request(CMD_ALLOC, 4095, 0);     // fills the rest of the region
    queue_request(CMD_ALLOC, 1, 0);        // region full
    queue_request(CMD_FREE, 0, 1);
    queue_request(CMD_ALLOC, 4094, 0);     // reuse at offset 1 with a smaller size
    queue_request(CMD_ALLOC, 1, 0);        // appended at the last word
    queue_request(CMD_FREE, 0, 4095);
    queue_request(CMD_FREE, 0, 2);         // stale interior offset
    queue_request(CMD_FREE, 0, 0);
    queue_request(CMD_FREE, 0, 1);
    queue_request(CMD_ALLOC, 2, 0);        // first block too small, second fits
    queue_request(CMD_ALLOC, 1, 0);
    queue_request(CMD_FREE, 0, 0);
    queue_request(CMD_FREE, 0, 1);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Random part: mostly allocations and frees of live blocks, some noise.
    for (int n = 0; n < 600; n++) begin
      while (pending_requests.size() >= 2) @(posedge clk);
      pick = $urandom_range(0, 99);
      if (pick < 40 && live_blocks.size() != 0) begin
        idx = $urandom_range(0, live_blocks.size() - 1);
        queue_request(CMD_FREE, $urandom_range(0, 8191), live_blocks[idx]);
        live_blocks.delete(idx);
      end else if (pick < 46) begin
        queue_request(CMD_FREE, $urandom_range(0, 8191), $urandom_range(0, 4095));
      end else if (pick < 50) begin
        case ($urandom_range(0, 3))
          0: size = 0;
          1: size = $urandom_range(4097, 8191);
          2: size = 4096;
          default: size = $urandom_range(1024, 4095);
        endcase
        queue_request(CMD_ALLOC, size, $urandom_range(0, 4095));
      end else begin
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 128);
        queue_request(CMD_ALLOC, size, $urandom_range(0, 4095));
      end
    end

    // Drain, then allow a short settling time for any stray response.
    while (pending_requests.size() != 0 || s_tvalid || expected_responses.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/hwba_pkg.sv
rtl/hwba_mem.sv
rtl/hwba_ctrl.sv
rtl/header_walk_block_allocator_top.sv
rtl/hwba_chk.sv
tb/tb.sv
